>>> hdl/srcp_pkg.sv
// ----------------------------------------------------------------------------
// SMTP reply code parser package
// Shared types and constants for the reply code parser block.
// ----------------------------------------------------------------------------
package srcp_pkg;

  // Parse phase of the current reply line.
  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,   // skipping toward the examined byte of a line
    PH_CONT = 2'd1,   // continuation line, waiting for its newline
    PH_LAST = 2'd2    // last line, waiting for the final newline
  } phase_t;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned CODE_W = 10;

  localparam logic [CODE_W-1:0] TRAIL_CODE = 10'd666;
  localparam logic [2:0]        SKIP_INIT  = 3'd3;
  localparam logic [1:0]        CODE_BYTES = 2'd3;

  // One received byte as held by the input stage.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_chunk;
  } item_t;

  // Result of processing one byte.
  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] reply_code;
    logic              trailing_error;
  } result_t;

  // Internal status exported for checking.
  typedef struct packed {
    logic       err_pend;
    logic [2:0] skip_left;
  } status_t;

endpackage

>>> hdl/srcp_in_stage.sv
// ----------------------------------------------------------------------------
// Input stage
// Registers one incoming byte transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module srcp_in_stage
  import srcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       take,
  output logic       item_vld,
  output item_t      item
);

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;

  // The stage can refill in the same cycle that the core empties it.
  assign in_tready = !vld_r || take;
  assign vld_nxt   = (vld_r && !take) || (in_tvalid && in_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.rx_byte      <= in_tdata;
      item_r.end_of_chunk <= in_tlast;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

>>> hdl/srcp_core.sv
// ----------------------------------------------------------------------------
// Parse core
// Holds the parse state, updated for one byte per cycle while take is high.
// ----------------------------------------------------------------------------
module srcp_core
  import srcp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    take,
  input  item_t   item,
  output result_t res,
  output status_t sts
);

  logic [CODE_W-1:0] code_value_r, code_value_nxt;
  logic [1:0]        bytes_seen_r, bytes_seen_nxt;
  logic              stopped_r, stopped_nxt;
  logic [2:0]        skip_left_r, skip_left_nxt;
  phase_t            phase_r, phase_nxt;
  logic              err_pend_r, err_pend_nxt;

  logic              is_digit;
  logic              is_nl;
  logic              done;
  logic [CODE_W-1:0] code_acc;

  assign is_digit = (item.rx_byte >= CH_ZERO) && (item.rx_byte <= CH_NINE);
  assign is_nl    = (item.rx_byte == CH_NL);

  // code * 10 + digit, wrapped to the code width.
  assign code_acc = {code_value_r[CODE_W-4:0], 3'b000}
                  + {code_value_r[CODE_W-2:0], 1'b0}
                  + {{(CODE_W-4){1'b0}}, item.rx_byte[3:0]};

  // Next state.
  always_comb begin
    code_value_nxt = code_value_r;
    bytes_seen_nxt = bytes_seen_r;
    stopped_nxt    = stopped_r;
    skip_left_nxt  = skip_left_r;
    phase_nxt      = phase_r;
    err_pend_nxt   = err_pend_r;
    done           = 1'b0;

    if (err_pend_r) begin
      // Discarding trailing bytes; the chunk end starts a fresh reply.
      if (item.end_of_chunk) begin
        err_pend_nxt   = 1'b0;
        code_value_nxt = '0;
        bytes_seen_nxt = '0;
        stopped_nxt    = 1'b0;
        skip_left_nxt  = SKIP_INIT;
        phase_nxt      = PH_SKIP;
      end
    end else begin
      if (bytes_seen_r < CODE_BYTES) begin
        if (!stopped_r && is_digit) begin
          code_value_nxt = code_acc;
        end else begin
          stopped_nxt = 1'b1;
        end
        bytes_seen_nxt = bytes_seen_r + 2'd1;
      end

      unique case (phase_r)
        PH_CONT: begin
          if (is_nl) begin
            skip_left_nxt = SKIP_INIT;
            phase_nxt     = PH_SKIP;
          end
        end
        PH_LAST: begin
          done = is_nl;
        end
        default: begin
          if (skip_left_r != 3'd0) begin
            skip_left_nxt = skip_left_r - 3'd1;
          end else if (item.rx_byte == CH_DASH) begin
            phase_nxt = PH_CONT;
          end else if (is_nl) begin
            done = 1'b1;
          end else begin
            phase_nxt = PH_LAST;
          end
        end
      endcase

      if (done) begin
        if (item.end_of_chunk) begin
          code_value_nxt = '0;
          bytes_seen_nxt = '0;
          stopped_nxt    = 1'b0;
          skip_left_nxt  = SKIP_INIT;
          phase_nxt      = PH_SKIP;
        end else begin
          err_pend_nxt = 1'b1;
        end
      end
    end
  end

  // Result for the byte at the core input.
  always_comb begin
    res.done           = done;
    res.trailing_error = !item.end_of_chunk;
    res.reply_code     = item.end_of_chunk ? code_value_nxt : TRAIL_CODE;
    if (item.end_of_chunk) begin
      // The reply restarts on this byte, so report the pre-restart value.
      res.reply_code = (bytes_seen_r < CODE_BYTES && !stopped_r && is_digit)
                     ? code_acc : code_value_r;
    end
  end

  assign sts.err_pend  = err_pend_r;
  assign sts.skip_left = skip_left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_value_r <= '0;
      bytes_seen_r <= '0;
      stopped_r    <= 1'b0;
      skip_left_r  <= SKIP_INIT;
      phase_r      <= PH_SKIP;
      err_pend_r   <= 1'b0;
    end else if (take) begin
      code_value_r <= code_value_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      stopped_r    <= stopped_nxt;
      skip_left_r  <= skip_left_nxt;
      phase_r      <= phase_nxt;
      err_pend_r   <= err_pend_nxt;
    end
  end

endmodule

>>> hdl/smtp_reply_code_parser.sv
// ----------------------------------------------------------------------------
// SMTP reply code parser
// Parses a stream of reply bytes and reports the reply code of each reply.
// ----------------------------------------------------------------------------
//
//   Channel  Role    Ports                        Content
//   in_      slave   tvalid tready tdata tlast    reply byte; tlast marks chunk end
//   out_     master  tvalid tready tdata tuser    reply code; tuser = trailing error
//
// One byte is accepted every cycle while the result side keeps up. A byte
// is held in the input register while the parse core processes it, and
// its result is loaded into the output register when the core takes the
// byte; the output register offers it. Reset is synchronous and active
// low; it clears all control state and the parse state. When the output
// register holds a result that is not taken, the core stalls, and a byte
// held in the input register stays there with in_tready low.
//
// The parser skips three bytes into each line and examines the fourth. A
// dash there marks a continuation line, which ends at its newline; any other
// byte marks the last line, complete at its newline. The leading decimal
// digits among the first three bytes of the reply form the code. If the reply
// completes on a byte that is not the last of its chunk, the result carries
// code 666 with the trailing error flag set, and the remaining bytes of the
// chunk are dropped.
// ----------------------------------------------------------------------------
module smtp_reply_code_parser
  import srcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input transaction.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // end_of_chunk
  // Result transaction.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] reply_code, [15:10] zero
  output logic [0:0]  out_tuser   // [0] trailing_error
);

  logic    item_vld;
  item_t   item;
  logic    take;
  result_t res;
  status_t sts;

  logic              out_vld_r, out_vld_nxt;
  logic [CODE_W-1:0] out_code_r;
  logic              out_err_r;

  // A held byte advances the core whenever the output register has room.
  assign take = item_vld && (!out_vld_r || out_tready);

  srcp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .take      (take),
    .item_vld  (item_vld),
    .item      (item)
  );

  srcp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (item),
    .res   (res),
    .sts   (sts)
  );

  // Output register: loaded by a completing byte, emptied by the consumer.
  assign out_vld_nxt = (take && res.done) || (out_vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.done) begin
      out_code_r <= res.reply_code;
      out_err_r  <= res.trailing_error;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = {6'b000000, out_code_r};
  assign out_tuser[0] = out_err_r;

`ifndef SYNTHESIS
  // A trailing error result always carries the fixed error code.
  a_trail_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[9:0] == TRAIL_CODE)
    else $error("trailing error result without error code");

  // No reply completes while trailing bytes are being discarded.
  a_no_done_in_discard: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && sts.err_pend |-> !res.done)
    else $error("result produced while discarding trailing bytes");

  // The skip counter never exceeds its start value.
  a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
    sts.skip_left <= SKIP_INIT)
    else $error("skip counter out of range");

  // A byte the core does not take stays in the input register.
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && !take |=> item_vld && $stable(item))
    else $error("input item lost while stalled");
`endif

endmodule

>>> tb/sv/tb_smtp_reply_code_parser.sv
// ----------------------------------------------------------------------------
// SMTP reply code parser testbench
// Streams single-line and multi-line replies, noise and broken replies into
// the parser, predicts every reply code and trailing error in a scoreboard,
// and checks each result transaction against it under varied flow control.
// ----------------------------------------------------------------------------
module tb_smtp_reply_code_parser;
  import srcp_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int PHASE_BYTES  = 150;
  localparam int DRAIN_CYCLES = 20;
  // Roughly 650 bytes; even a slow run with both sides idling stays far below.
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              trailing;
  } reply_t;

  // Tracks the parse state of the stream and holds the replies still owed.
  class reply_scoreboard;
    reply_t            owed_replies[$];
    logic [CODE_W-1:0] code_acc;
    logic [1:0]        code_len;
    logic              digit_run_over;
    logic [2:0]        skip_cnt;
    phase_t            line_phase;
    logic              dropping_chunk;
    int                mismatches;
    int                replies_checked;
    int                trailing_seen;

    function new();
      mismatches      = 0;
      replies_checked = 0;
      trailing_seen   = 0;
      dropping_chunk  = 1'b0;
      restart_reply();
    endfunction

    function void restart_reply();
      code_acc       = '0;
      code_len       = 2'd0;
      digit_run_over = 1'b0;
      skip_cnt       = SKIP_INIT;
      line_phase     = PH_SKIP;
    endfunction

    // Advances the parse state by one accepted byte and queues any reply it completes.
    function void note_byte(logic [7:0] b, logic chunk_end);
      logic   complete;
      reply_t r;
      complete = 1'b0;
      if (dropping_chunk) begin
        if (chunk_end) begin
          dropping_chunk = 1'b0;
          restart_reply();
        end
        return;
      end
      if (code_len < CODE_BYTES) begin
        if (!digit_run_over && b >= CH_ZERO && b <= CH_NINE) begin
          code_acc = CODE_W'(code_acc * 10 + (b - CH_ZERO));
        end else begin
          digit_run_over = 1'b1;
        end
        code_len = code_len + 2'd1;
      end
      case (line_phase)
        PH_CONT: begin
          if (b == CH_NL) begin
            skip_cnt   = SKIP_INIT;
            line_phase = PH_SKIP;
          end
        end
        PH_LAST: begin
          if (b == CH_NL) complete = 1'b1;
        end
        default: begin
          if (skip_cnt != 3'd0) begin
            skip_cnt = skip_cnt - 3'd1;
          end else if (b == CH_DASH) begin
            line_phase = PH_CONT;
          end else if (b == CH_NL) begin
            complete = 1'b1;
          end else begin
            line_phase = PH_LAST;
          end
        end
      endcase
      if (!complete) return;
      if (chunk_end) begin
        r.code     = code_acc;
        r.trailing = 1'b0;
        restart_reply();
      end else begin
        r.code         = TRAIL_CODE;
        r.trailing     = 1'b1;
        dropping_chunk = 1'b1;
      end
      owed_replies.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_reply(logic [15:0] data, logic trailing);
      reply_t r;
      if (owed_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result code=%0d trailing=%0b",
                                  data[CODE_W-1:0], trailing));
        return;
      end
      r = owed_replies.pop_front();
      replies_checked++;
      if (r.trailing) trailing_seen++;
      if (data[CODE_W-1:0] !== r.code)
        report_mismatch($sformatf("reply_code %0d, expected %0d",
                                  data[CODE_W-1:0], r.code));
      if (trailing !== r.trailing)
        report_mismatch($sformatf("trailing_error %0b, expected %0b", trailing, r.trailing));
      if (data[15:CODE_W] !== '0)
        report_mismatch($sformatf("tdata padding bits are %b", data[15:CODE_W]));
    endtask

    task check_leftovers();
      if (owed_replies.size() != 0)
        report_mismatch($sformatf("%0d expected results never arrived", owed_replies.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;

  reply_scoreboard sb = new();

  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  int bytes_sent        = 0;
  int cycle_count       = 0;

  // Bytes of the next stretch of stimulus, with their end-of-chunk flags.
  logic [7:0] seq_bytes[$];
  logic       seq_last[$];

  smtp_reply_code_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // The receiver stalls at random with the probability of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Both channels are sampled at the clock edge, before any register updates.
  // An input accepted at this edge cannot produce its result at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_reply(out_tdata, out_tuser[0]);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function void add_byte(logic [7:0] b, logic last);
    seq_bytes.push_back(b);
    seq_last.push_back(last);
  endfunction

  function void add_text(string s, logic last_on_end);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], last_on_end && (i == s.len() - 1));
  endfunction

  function logic [7:0] any_but_newline();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_NL);
    return b;
  endfunction

  // Neither a dash nor a newline, so the examined byte opens the last line.
  function logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_NL || b == CH_DASH);
    return b;
  endfunction

  // Mostly digits, so that codes are usually real; otherwise any byte at all.
  function logic [7:0] code_char();
    if ($urandom_range(99) < 85) return CH_ZERO + 8'($urandom_range(9));
    return 8'($urandom_range(255));
  endfunction

  // A well-formed reply: zero to two continuation lines, then the last line.
  // Most end their chunk at the final newline; some carry trailing bytes, and
  // some have a chunk boundary earlier in the reply.
  function void add_reply();
    int         n_cont;
    int         start_idx;
    int         text_len;
    logic [7:0] sep;
    n_cont    = $urandom_range(2);
    start_idx = seq_bytes.size();
    for (int line = 0; line <= n_cont; line++) begin
      for (int i = 0; i < 3; i++) add_byte(code_char(), 1'b0);
      if (line < n_cont) sep = CH_DASH;
      else if ($urandom_range(99) < 20) sep = CH_NL;
      else sep = plain_byte();
      add_byte(sep, 1'b0);
      if (sep != CH_NL) begin
        text_len = $urandom_range(4);
        for (int i = 0; i < text_len; i++) add_byte(any_but_newline(), 1'b0);
        add_byte(CH_NL, 1'b0);
      end
    end
    if ($urandom_range(99) < 15)
      seq_last[$urandom_range(seq_bytes.size() - 2, start_idx)] = 1'b1;
    if ($urandom_range(99) < 25) begin
      text_len = $urandom_range(3, 1);
      for (int i = 0; i < text_len; i++) add_byte(8'($urandom_range(255)), i == text_len - 1);
    end else begin
      seq_last[seq_bytes.size() - 1] = 1'b1;
    end
  endfunction

  // From any parse state this brings the stream back to the start of a reply.
  function void add_resync();
    add_byte(CH_NL, 1'b0);
    for (int i = 0; i < 4; i++) add_byte(plain_byte(), 1'b0);
    add_byte(CH_NL, 1'b1);
  endfunction

  function void add_noise();
    int n;
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++)
      add_byte(8'($urandom_range(255)), $urandom_range(99) < 25);
    add_resync();
  endfunction

  // A reply cut short at a random point, followed by a resync.
  function void add_broken_reply();
    int cut;
    add_reply();
    cut = $urandom_range(seq_bytes.size() - 1, 1);
    for (int i = 0; i < cut && seq_bytes.size() > 1; i++) begin
      void'(seq_bytes.pop_back());
      void'(seq_last.pop_back());
    end
    add_resync();
  endfunction

  // Holds one byte on the input channel until the parser takes it. The sender
  // may first idle for a random number of cycles.
  task send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task send_queued();
    while (seq_bytes.size() != 0) send_byte(seq_bytes.pop_front(), seq_last.pop_front());
  endtask

  initial begin
    int phase_start;
    int pick;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed replies: the largest code with the examined byte a newline, a
    // continuation line whose chunk ends on the dash, a zero byte that stops
    // the digit run, and a reply completing mid-chunk that ends on 0xFF.
    add_text("999\n", 1'b1);
    add_text("000", 1'b0);
    add_byte(CH_DASH, 1'b1);
    add_text("\nabc \n", 1'b1);
    add_byte(8'h00, 1'b0);
    add_text("55 \n", 1'b1);
    add_text("421\nZ", 1'b0);
    add_byte(8'hFF, 1'b1);
    send_queued();

    // Random part, in four flow-control phases: none, sender idling,
    // receiver stalling, and both at once.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 83; end
        default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 82) add_reply();
        else if (pick < 91) add_noise();
        else add_broken_reply();
        send_queued();
      end
    end
    in_tvalid <= 1'b0;

    while (sb.owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_leftovers();

    $display("Drove %0d reply bytes through four flow-control phases.", bytes_sent);
    $display("Checked %0d replies, %0d of them flagged with trailing bytes; %0d mismatches.",
             sb.replies_checked, sb.trailing_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/srcp_pkg.sv
hdl/srcp_in_stage.sv
hdl/srcp_core.sv
hdl/smtp_reply_code_parser.sv
tb/sv/tb_smtp_reply_code_parser.sv
